/* rtl/core/rcd_pkg.sv */
package rcd_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MaxBlockDef = 256;
  localparam int unsigned PreShiftDef = 14;

  // Fixed field and state widths.
  localparam int unsigned MicW    = 32;
  localparam int unsigned ThrW    = 17;
  localparam int unsigned MsW     = 16;
  localparam int unsigned ElapsW  = 17;
  localparam int unsigned TallyW  = 4;
  localparam int unsigned SumW    = 43;
  localparam int unsigned NeedW   = 2 * ThrW + 1;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [TallyW-1:0] TallyMax   = '1;
  localparam logic [ElapsW-1:0] ElapsedMax = '1;
  localparam logic [SumW-1:0]   SumMax     = '1;

  // Register reset values.
  localparam logic [ThrW-1:0] ThrRst    = ThrW'(30000);
  localparam logic [MsW-1:0]  CoolRst   = MsW'(300);
  localparam logic [MsW-1:0]  WindowRst = MsW'(800);
  localparam logic [MsW-1:0]  HoldRst   = MsW'(3000);

  // Queue depths.
  localparam int unsigned InQueueDepth  = 2;
  localparam int unsigned ResQueueDepth = 2;

  typedef enum logic {
    ModeSample = 1'b0,
    ModeTick   = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    EvClap   = 2'd0,
    EvSingle = 2'd1,
    EvDouble = 2'd2
  } ev_kind_e;

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegCooldown  = 2'd1,
    RegWindow    = 2'd2,
    RegHold      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    mode_e                  mode;
    logic signed [MicW-1:0] mic_word;
    logic                   block_end;
    logic                   playback_busy;
  } in_item_t;

  typedef struct packed {
    ev_kind_e          event_kind;
    logic [TallyW-1:0] clap_number;
  } out_item_t;

  // Entry of the queue between the front and the back.
  typedef struct packed {
    mode_e           mode;
    logic [MicW-1:0] mic_word;
    logic            block_end;
  } q_item_t;

  typedef struct packed {
    logic [ThrW-1:0] loud_threshold;
    logic [MsW-1:0]  clap_cooldown_ms;
    logic [MsW-1:0]  double_window_ms;
    logic [MsW-1:0]  report_hold_ms;
  } cfg_t;

  // Per-item status from the energy pipeline to the decision stage.
  typedef struct packed {
    logic valid;
    logic tick;
    logic done;
    logic loud;
  } blk_t;

endpackage

/* rtl/core/rcd_fifo.sv */
module rcd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  // A transfer out frees a slot for a transfer in on the same edge.
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (!full_o || do_pop);

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/rcd_regs.sv */
module rcd_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcd_pkg::ApbAddrW-1:0] paddr,
  input  logic [rcd_pkg::ApbDataW-1:0] pwdata,
  output logic [rcd_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output rcd_pkg::cfg_t                cfg_o
);

  import rcd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // Register write decode; values are cut to the register width.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegThreshold: cfg_d.loud_threshold   = pwdata[ThrW-1:0];
        RegCooldown:  cfg_d.clap_cooldown_ms = pwdata[MsW-1:0];
        RegWindow:    cfg_d.double_window_ms = pwdata[MsW-1:0];
        RegHold:      cfg_d.report_hold_ms   = pwdata[MsW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loud_threshold   <= ThrRst;
      cfg_q.clap_cooldown_ms <= CoolRst;
      cfg_q.double_window_ms <= WindowRst;
      cfg_q.report_hold_ms   <= HoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      RegThreshold: prdata = ApbDataW'(cfg_q.loud_threshold);
      RegCooldown:  prdata = ApbDataW'(cfg_q.clap_cooldown_ms);
      RegWindow:    prdata = ApbDataW'(cfg_q.double_window_ms);
      RegHold:      prdata = ApbDataW'(cfg_q.report_hold_ms);
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/core/rcd_front.sv */
module rcd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rcd_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output rcd_pkg::q_item_t  head_o,
  output logic              empty_o
);

  import rcd_pkg::*;

  q_item_t entry;
  logic    keep;
  logic    accept;

  // Items that arrive during playback are dropped here and never reach the back.
  assign accept = push_i && !full_o;
  assign keep   = accept && !item_i.playback_busy;

  assign entry.mode      = item_i.mode;
  assign entry.mic_word  = item_i.mic_word;
  assign entry.block_end = item_i.block_end;

  rcd_fifo #(
    .Width ($bits(q_item_t)),
    .Depth (InQueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (keep),
    .wdata_i (entry),
    .pop_i   (pop_i),
    .rdata_o (head_o),
    .full_o  (full_o),
    .empty_o (empty_o)
  );

endmodule

/* rtl/core/rcd_energy.sv */
module rcd_energy #(
  parameter int unsigned MaxBlock = rcd_pkg::MaxBlockDef,
  parameter int unsigned PreShift = rcd_pkg::PreShiftDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     q_valid_i,
  input  rcd_pkg::q_item_t         q_item_i,
  input  logic [rcd_pkg::ThrW-1:0] thr_i,
  output rcd_pkg::blk_t            blk_o
);

  import rcd_pkg::*;

  localparam int unsigned MagW = MicW - PreShift;
  localparam int unsigned SqW  = 2 * MagW - 1;
  localparam int unsigned CntW = $clog2(MaxBlock + 1);
  localparam int unsigned AccW = NeedW + CntW;
  localparam int unsigned AddW = ((SumW > SqW) ? SumW : SqW) + 1;
  localparam int unsigned CmpW = (SumW > AccW) ? SumW : AccW;

  // Magnitude of the shifted sample and its square.
  logic [MicW-1:0]   inv_word, shr_pos, shr_neg;
  logic [MagW-1:0]   mag;
  logic [2*MagW-1:0] prod;

  assign inv_word = ~q_item_i.mic_word;
  assign shr_pos  = q_item_i.mic_word >> PreShift;
  assign shr_neg  = inv_word >> PreShift;
  assign mag      = q_item_i.mic_word[MicW-1] ? (shr_neg[MagW-1:0] + 1'b1)
                                              : shr_pos[MagW-1:0];
  assign prod     = mag * mag;

  // Required energy per sample, (threshold + 1) squared.
  logic [ThrW:0]       thr_p1;
  logic [2*ThrW+1:0]   need_full;
  logic [NeedW-1:0]    need_q;

  assign thr_p1    = {1'b0, thr_i} + 1'b1;
  assign need_full = thr_p1 * thr_p1;

  always_ff @(posedge clk_i) begin
    need_q <= need_full[NeedW-1:0];
  end

  // Stage one: square.
  logic           s1_v_q, s1_tick_q, s1_last_q;
  logic [SqW-1:0] s1_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_tick_q <= (q_item_i.mode == ModeTick);
      s1_last_q <= q_item_i.block_end;
      s1_sq_q   <= prod[SqW-1:0];
    end
  end

  // Stage two: block accumulation of the squares and of the sample count.
  logic [SumW-1:0] sum_q, sum_d, fin_sum_q;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_new, fin_cnt_q;
  logic [AddW-1:0] sum_wide;
  logic [SumW-1:0] sum_new;
  logic            s2_v_q, s2_tick_q, s2_done_q;
  logic            sample_en, done;

  assign sample_en = en_i && s1_v_q && !s1_tick_q;
  assign sum_wide  = AddW'(sum_q) + AddW'(s1_sq_q);
  assign sum_new   = (sum_wide >= AddW'(SumMax)) ? SumMax : sum_wide[SumW-1:0];
  assign cnt_new   = cnt_q + 1'b1;
  assign done      = s1_last_q || (cnt_new == CntW'(MaxBlock));

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (sample_en) begin
      if (done) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      s2_v_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (en_i) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_tick_q <= s1_tick_q;
      s2_done_q <= !s1_tick_q && done;
    end
    if (sample_en && done) begin
      fin_sum_q <= sum_new;
      fin_cnt_q <= cnt_new;
    end
  end

  // Stage three: a finished block is loud when its sum reaches the required
  // energy per sample times its sample count.
  logic [AccW-1:0] need_tot;
  logic            blk_v_q, blk_tick_q, blk_done_q, blk_loud_q;

  assign need_tot = AccW'(need_q) * AccW'(fin_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_v_q <= 1'b0;
    end else if (en_i) begin
      blk_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_tick_q <= s2_tick_q;
      blk_done_q <= s2_done_q;
      blk_loud_q <= (CmpW'(fin_sum_q) >= CmpW'(need_tot));
    end
  end

  assign blk_o = '{valid: blk_v_q, tick: blk_tick_q, done: blk_done_q, loud: blk_loud_q};

endmodule

/* rtl/core/rcd_decide.sv */
module rcd_decide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  rcd_pkg::blk_t      blk_i,
  input  rcd_pkg::cfg_t      cfg_i,
  output logic               res_v_o,
  output rcd_pkg::out_item_t res_o
);

  import rcd_pkg::*;

  logic [TallyW-1:0] tally_q, tally_d, tally_inc;
  logic [ElapsW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [MsW-1:0]    left_q, left_d;
  logic              active_q, active_d;
  logic              step;

  assign step        = en_i && blk_i.valid;
  assign tally_inc   = (tally_q == TallyMax) ? tally_q : tally_q + 1'b1;
  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;

  // Clap counting, cooldown, decision window and report hold, one item at a time in order.
  always_comb begin
    tally_d           = tally_q;
    elapsed_d         = elapsed_q;
    left_d            = left_q;
    active_d          = active_q;
    res_v_o           = 1'b0;
    res_o.event_kind  = EvClap;
    res_o.clap_number = tally_q;
    if (step) begin
      if (blk_i.tick) begin
        if (active_q) begin
          if (left_q == '0) begin
            active_d = 1'b0;
          end else begin
            left_d = left_q - 1'b1;
          end
        end
        if (tally_q != '0) begin
          if (elapsed_inc > ElapsW'(cfg_i.double_window_ms)) begin
            res_v_o          = 1'b1;
            res_o.event_kind = (tally_q >= TallyW'(2)) ? EvDouble : EvSingle;
            tally_d          = '0;
            elapsed_d        = '0;
            active_d         = 1'b1;
            left_d           = cfg_i.report_hold_ms;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end else if (blk_i.done && blk_i.loud && !active_q) begin
        if (tally_q == '0) begin
          elapsed_d = '0;
        end
        tally_d           = tally_inc;
        active_d          = 1'b1;
        left_d            = cfg_i.clap_cooldown_ms;
        res_v_o           = 1'b1;
        res_o.clap_number = tally_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q   <= '0;
      elapsed_q <= '0;
      left_q    <= '0;
      active_q  <= 1'b0;
    end else begin
      tally_q   <= tally_d;
      elapsed_q <= elapsed_d;
      left_q    <= left_d;
      active_q  <= active_d;
    end
  end

endmodule

/* rtl/core/rms_clap_detector.sv */
// Path of an item: input queue, square, sum and compare registers, result queue.
// Throughput: one item per cycle; the energy pipeline and the decision stage advance
// together whenever the result queue can take a transfer.
// Reset: rst_ni clears the queues, block sum, clap state and cooldown at once, and
// returns the registers to their default values; no clearing pass is needed.
module rms_clap_detector #(
  parameter int unsigned MaxBlock = rcd_pkg::MaxBlockDef,
  parameter int unsigned PreShift = rcd_pkg::PreShiftDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  rcd_pkg::in_item_t            in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output rcd_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcd_pkg::ApbAddrW-1:0] paddr,
  input  logic [rcd_pkg::ApbDataW-1:0] pwdata,
  output logic [rcd_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  import rcd_pkg::*;

  cfg_t      cfg;
  q_item_t   q_head;
  logic      q_empty;
  logic      en;
  blk_t      blk;
  logic      res_v;
  out_item_t res;
  logic      res_full;

  rcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The back advances when the result queue has room or is giving up its head.
  assign en = !res_full || (pop && !empty);

  rcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .pop_i   (en),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  rcd_energy #(
    .MaxBlock (MaxBlock),
    .PreShift (PreShift)
  ) u_energy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .q_valid_i (!q_empty),
    .q_item_i  (q_head),
    .thr_i     (cfg.loud_threshold),
    .blk_o     (blk)
  );

  rcd_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .blk_i   (blk),
    .cfg_i   (cfg),
    .res_v_o (res_v),
    .res_o   (res)
  );

  rcd_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (ResQueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_v),
    .wdata_i (res),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .full_o  (res_full),
    .empty_o (empty)
  );

endmodule

/* rtl/core/rcd_checker.sv */
module rcd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input rcd_pkg::out_item_t out_item_o
);

  import rcd_pkg::*;

  // No result may be offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result offered during reset");

  // A single report always carries exactly one clap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.event_kind == EvSingle) |-> out_item_o.clap_number == TallyW'(1))
    else $error("single report with wrong clap count");

  // A double report carries at least two claps, a clap event at least one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.event_kind == EvDouble) |-> out_item_o.clap_number >= TallyW'(2))
    else $error("double report with too few claps");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.event_kind == EvClap) |-> out_item_o.clap_number != '0)
    else $error("clap event with zero count");

  // A result that is not taken stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before its transfer");

endmodule

bind rms_clap_detector rcd_checker u_rcd_checker (.*);
